### rtl/core/preemptive_priority_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Property must hold at every clock edge out of reset
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true out of reset
`define PPS_ASSERT_NEVER(lbl, cond, msg) \
  `PPS_ASSERT(lbl, !(cond), msg)

`endif

### rtl/core/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; used by pps_front, pps_back and the top level.
`timescale 1ns / 1ps

package pps_pkg;

  // Default table depth
  localparam int MaxTasksDef = 16;

  // Field widths
  localparam int TimeW   = 32;
  localparam int FieldW  = 16;
  localparam int PrioW   = 8;
  localparam int SlotOutW = 4;

  // Depth of the queue between front and back
  localparam int QDepth = 2;

  // Command kinds as classified by the front
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LOAD_BAD,
    CMD_TICK
  } cmd_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_LOAD_OK,
    STAT_LOAD_REJ,
    STAT_TICK_IDLE,
    STAT_TICK_RUN
  } status_e;

  // Queued command
  typedef struct packed {
    cmd_kind_e         kind;
    logic [FieldW-1:0] arrival;
    logic [FieldW-1:0] burst;
    logic [PrioW-1:0]  prio;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    status_e             status;
    logic [SlotOutW-1:0] slot;
    logic                finished;
    logic [TimeW-1:0]    completion_time;
    logic [TimeW-1:0]    turnaround;
    logic [TimeW-1:0]    waiting;
    logic                all_done;
  } res_t;

endpackage

### rtl/core/pps_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on pps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_macros.svh"

module pps_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic [pps_pkg::FieldW-1:0]   arrival_time_i,
  input  logic [pps_pkg::FieldW-1:0]   burst_length_i,
  input  logic [pps_pkg::PrioW-1:0]    task_priority_i,
  output logic                         cmd_valid_o,
  output pps_pkg::cmd_t                cmd_o,
  input  logic                         cmd_ready_i
);

  localparam int QPtrW = $clog2(pps_pkg::QDepth);
  localparam int QCntW = $clog2(pps_pkg::QDepth + 1);

  pps_pkg::cmd_t   q_mem_q [pps_pkg::QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  pps_pkg::cmd_t   cmd_in;
  logic            push, pop;

  // Classify: ticks, good loads, zero-burst loads
  always_comb begin
    cmd_in.arrival = arrival_time_i;
    cmd_in.burst   = burst_length_i;
    cmd_in.prio    = task_priority_i;
    if (req_type_i) begin
      cmd_in.kind = pps_pkg::CMD_TICK;
    end else if (burst_length_i == '0) begin
      cmd_in.kind = pps_pkg::CMD_LOAD_BAD;
    end else begin
      cmd_in.kind = pps_pkg::CMD_LOAD;
    end
  end

  assign busy_o      = (cnt_q == QCntW'(pps_pkg::QDepth));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(pps_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(pps_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PPS_ASSERT_NEVER(a_q_overfill, cnt_q > QCntW'(pps_pkg::QDepth), "queue count above depth")

endmodule

### rtl/core/pps_back.sv
// Back end: task table, priority scan over the table and result generation.
// Depends on pps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "preemptive_priority_scheduler_macros.svh"

module pps_back #(
  parameter int MaxTasks = pps_pkg::MaxTasksDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  pps_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output pps_pkg::res_t res_o
);

  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW  = $clog2(MaxTasks + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  typedef struct packed {
    logic [pps_pkg::FieldW-1:0] arrival;
    logic [pps_pkg::FieldW-1:0] burst;
    logic [pps_pkg::FieldW-1:0] remaining;
    logic [pps_pkg::PrioW-1:0]  prio;
  } task_t;

  logic [2:0]                 state_q, state_d;
  pps_pkg::cmd_t              cmd_q;
  task_t                      task_mem_q [MaxTasks];
  task_t                      rd_word_q;
  task_t                      wr_word;
  logic [SlotW-1:0]           wr_addr;
  logic                       wr_en;
  logic [SlotW-1:0]           scan_idx_q, eval_idx_q, best_idx_q;
  logic                       eval_vld_q, found_q;
  task_t                      best_word_q;
  logic [MaxTasks-1:0]        done_q;
  logic [CntW-1:0]            loaded_q, done_cnt_q;
  logic [pps_pkg::TimeW-1:0]  now_q, tat_q;
  logic                       fin_q;
  logic                       res_valid_q;
  pps_pkg::res_t              res_q;
  logic                       pop, table_full, load_ok, eligible, take;
  logic [pps_pkg::FieldW-1:0] rem_next;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign table_full  = (loaded_q == CntW'(MaxTasks));
  assign load_ok     = (cmd_q.kind == pps_pkg::CMD_LOAD) && !table_full;
  assign rem_next    = best_word_q.remaining - 1'b1;

  // Scan compare on the entry read in the previous cycle
  assign eligible = eval_vld_q && (CntW'(eval_idx_q) < loaded_q) && !done_q[eval_idx_q] &&
                    ({{(pps_pkg::TimeW - pps_pkg::FieldW){1'b0}}, rd_word_q.arrival} <= now_q);
  assign take     = eligible && (!found_q || (rd_word_q.prio < best_word_q.prio));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          state_d = (cmd_i.kind == pps_pkg::CMD_TICK) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD:   state_d = S_IDLE;
      S_SCAN: begin
        if (scan_idx_q == SlotW'(MaxTasks - 1)) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_DECIDE;
      S_DECIDE: state_d = found_q ? S_UPDATE : S_IDLE;
      S_UPDATE: state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Table write port: new task on load, remaining work on update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_word = best_word_q;
    wr_word.remaining = rem_next;
    if (state_q == S_LOAD) begin
      wr_en             = load_ok;
      wr_addr           = SlotW'(loaded_q);
      wr_word.arrival   = cmd_q.arrival;
      wr_word.burst     = cmd_q.burst;
      wr_word.remaining = cmd_q.burst;
      wr_word.prio      = cmd_q.prio;
    end else if (state_q == S_UPDATE) begin
      wr_en = 1'b1;
    end
  end

  // Task memory, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      task_mem_q[wr_addr] <= wr_word;
    end
    rd_word_q <= task_mem_q[scan_idx_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    eval_idx_q <= scan_idx_q;
    if (pop) begin
      cmd_q <= cmd_i;
    end
    if (take) begin
      best_idx_q  <= eval_idx_q;
      best_word_q <= rd_word_q;
    end
    if (state_q == S_UPDATE) begin
      fin_q <= (rem_next == '0);
      tat_q <= now_q - {{(pps_pkg::TimeW - pps_pkg::FieldW){1'b0}}, best_word_q.arrival};
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD) begin
      res_q.status          <= load_ok ? pps_pkg::STAT_LOAD_OK : pps_pkg::STAT_LOAD_REJ;
      res_q.slot            <= load_ok ? pps_pkg::SlotOutW'(loaded_q) : '0;
      res_q.finished        <= 1'b0;
      res_q.completion_time <= '0;
      res_q.turnaround      <= '0;
      res_q.waiting         <= '0;
      res_q.all_done        <= load_ok ? (done_cnt_q == CntW'(loaded_q + 1'b1))
                                       : (done_cnt_q == loaded_q);
    end else if (state_q == S_DECIDE && !found_q) begin
      res_q.status          <= pps_pkg::STAT_TICK_IDLE;
      res_q.slot            <= '0;
      res_q.finished        <= 1'b0;
      res_q.completion_time <= '0;
      res_q.turnaround      <= '0;
      res_q.waiting         <= '0;
      res_q.all_done        <= (done_cnt_q == loaded_q);
    end else if (state_q == S_FINISH) begin
      res_q.status          <= pps_pkg::STAT_TICK_RUN;
      res_q.slot            <= pps_pkg::SlotOutW'(best_idx_q);
      res_q.finished        <= fin_q;
      res_q.completion_time <= fin_q ? now_q : '0;
      res_q.turnaround      <= fin_q ? tat_q : '0;
      res_q.waiting         <= fin_q ?
          (tat_q - {{(pps_pkg::TimeW - pps_pkg::FieldW){1'b0}}, best_word_q.burst}) : '0;
      res_q.all_done        <= (done_cnt_q == loaded_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_idx_q  <= '0;
      eval_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= '0;
      loaded_q    <= '0;
      done_cnt_q  <= '0;
      now_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      eval_vld_q <= (state_q == S_SCAN);
      // Scan counter walks every slot once per tick
      if (state_q == S_SCAN) begin
        scan_idx_q <= (scan_idx_q == SlotW'(MaxTasks - 1)) ? '0 : scan_idx_q + 1'b1;
      end
      if (pop) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      // Load fills the next free slot
      if (state_q == S_LOAD && load_ok) begin
        done_q[SlotW'(loaded_q)] <= 1'b0;
        loaded_q                 <= loaded_q + 1'b1;
      end
      // Time advances once per tick, before the chosen entry is updated
      if (state_q == S_DECIDE) begin
        now_q <= now_q + 1'b1;
      end
      if (state_q == S_UPDATE && rem_next == '0) begin
        done_q[best_idx_q] <= 1'b1;
        done_cnt_q         <= done_cnt_q + 1'b1;
      end
      res_valid_q <= (state_q == S_LOAD) || (state_q == S_FINISH) ||
                     (state_q == S_DECIDE && !found_q);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `PPS_ASSERT_NEVER(a_done_gt_loaded, done_cnt_q > loaded_q, "more tasks done than loaded")
  `PPS_ASSERT(a_strobe_single, res_valid_q |=> !res_valid_q, "result strobe held two cycles")
  `PPS_ASSERT(a_fin_is_run, res_valid_q && res_q.finished |-> res_q.status == pps_pkg::STAT_TICK_RUN, "finished on non-run")

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// Load result: strobed after the LOAD state, which writes the table. Tick
// result: strobed after a scan of the task memory at one slot per cycle, then
// DRAIN and DECIDE, then UPDATE and FINISH if a task ran. The back end takes a
// new request only when it is idle; a two-entry queue takes requests ahead.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (rst_ni low, async) empties the table, clears time and the queue.
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
  parameter int MaxTasks = pps_pkg::MaxTasksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [pps_pkg::FieldW-1:0]    arrival_time_i,
  input  logic [pps_pkg::FieldW-1:0]    burst_length_i,
  input  logic [pps_pkg::PrioW-1:0]     task_priority_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [pps_pkg::SlotOutW-1:0]  slot_o,
  output logic                          finished_o,
  output logic [pps_pkg::TimeW-1:0]     completion_time_o,
  output logic [pps_pkg::TimeW-1:0]     turnaround_o,
  output logic [pps_pkg::TimeW-1:0]     waiting_o,
  output logic                          all_done_o
);

  logic          cmd_valid, cmd_ready;
  pps_pkg::cmd_t cmd;
  pps_pkg::res_t res;

  // Front: accept and classify
  pps_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .req_type_i      (req_type_i),
    .arrival_time_i  (arrival_time_i),
    .burst_length_i  (burst_length_i),
    .task_priority_i (task_priority_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready)
  );

  // Back: table, scan, results
  pps_back #(
    .MaxTasks (MaxTasks)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (valid_o),
    .res_o       (res)
  );

  assign status_o          = res.status;
  assign slot_o            = res.slot;
  assign finished_o        = res.finished;
  assign completion_time_o = res.completion_time;
  assign turnaround_o      = res.turnaround;
  assign waiting_o         = res.waiting;
  assign all_done_o        = res.all_done;

endmodule
